// ----- rtl/pld_pkg.sv -----
`default_nettype none
package pld_pkg;
  localparam int MaxDegreeDefault = 31;
  localparam int CoeffW = 32;
  localparam int PowW = 5;
  localparam int Depth = 32;

  typedef struct packed {
    logic              poly_select;
    logic [PowW-1:0]   power;
    logic signed [CoeffW-1:0] coeff;
    logic              last;
  } req_t;

  typedef struct packed {
    logic              part;
    logic [PowW-1:0]   degree;
    logic [PowW-1:0]   term_power;
    logic signed [CoeffW-1:0] result_coeff;
    logic              error;
    logic              end_of_run;
  } res_t;
endpackage
`default_nettype wire

// ----- rtl/pld_cell.sv -----
`default_nettype none
// One remainder coefficient: subtract q times the divisor coefficient in its column.
module pld_cell
  import pld_pkg::*;
(
  input  wire logic clk,
  input  wire logic ld,
  input  wire logic [CoeffW-1:0] ld_val,
  input  wire logic sub_en,
  input  wire logic [CoeffW-1:0] prod,
  output logic [CoeffW-1:0] rem
);
  always_ff @(posedge clk) begin
    if (ld) begin
      rem <= ld_val;
    end else if (sub_en) begin
      rem <= rem - prod;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/pld_divider.sv -----
`default_nettype none
// Restoring signed divider, truncating toward zero, one quotient bit per cycle.
module pld_divider
  import pld_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  wire logic [CoeffW-1:0] a,
  input  wire logic [CoeffW-1:0] b,
  output logic done,
  output logic [CoeffW-1:0] q
);
  logic busy;
  logic [5:0] cnt;
  logic [CoeffW-1:0] mb, quo, rm;
  logic neg;
  logic [CoeffW:0] trial;
  logic [CoeffW-1:0] shifted_quo;

  assign trial = {rm, quo[CoeffW-1]} - {1'b0, mb};
  assign shifted_quo = {quo[CoeffW-2:0], ~trial[CoeffW]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt <= 6'd0;
        neg <= a[CoeffW-1] ^ b[CoeffW-1];
        quo <= a[CoeffW-1] ? -a : a;
        mb <= b[CoeffW-1] ? -b : b;
        rm <= '0;
      end else if (busy) begin
        rm <= trial[CoeffW] ? {rm[CoeffW-2:0], quo[CoeffW-1]} : trial[CoeffW-1:0];
        quo <= shifted_quo;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(CoeffW-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          q <= neg ? -shifted_quo : shifted_quo;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- rtl/polynomial_long_division.sv -----
`default_nettype none
// Channel  | Ports                     | Handshake
// request  | start, busy, req (req_t)  | taken when start && !busy
// result   | res_valid, res (res_t)    | one result per cycle, no stall
// Loading accepts one request per cycle while idle. A request with last starts a run:
// each quotient term is computed by the shared divider while in S_WAIT, then S_SUB
// lets the row of cells subtract q times the divisor; the remainder degree
// search walks one term a cycle; then one result a cycle. busy stays high
// through the whole run. Reset clears degrees and control; stores hold junk.
module polynomial_long_division
  import pld_pkg::*;
#(
  parameter int MAX_DEGREE = MaxDegreeDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic busy,
  output logic res_valid,
  output res_t res
);
  localparam int N = MAX_DEGREE + 1;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_WAIT, S_SUB, S_SCAN, S_OUTQ, S_OUTR}
    state_t;
  state_t state;

  logic [CoeffW-1:0] dstore [Depth];
  logic [CoeffW-1:0] qstore [Depth];
  logic [CoeffW-1:0] rem [N];
  logic [PowW-1:0] dd, vd, qd, rd, idx;
  logic [CoeffW-1:0] lead, qv;
  logic div_go, div_done;
  logic [CoeffW-1:0] div_q;
  logic acc;
  logic in_rng;

  assign acc = start && !busy;
  assign in_rng = int'(req.power) <= MAX_DEGREE;
  assign busy = state != S_IDLE;

  pld_divider u_div (.clk, .rst, .go(div_go), .a(rem[idx + vd]), .b(lead),
                     .done(div_done), .q(div_q));

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cells
      logic [PowW-1:0] j;
      logic in_win;
      assign j = PowW'(g) - idx;
      assign in_win = (g >= int'(idx)) && (int'(j) <= int'(vd));
      pld_cell u_cell (
        .clk,
        .ld(acc && in_rng && !req.poly_select && req.power == PowW'(g)),
        .ld_val(req.coeff),
        .sub_en(state == S_SUB && in_win),
        .prod(qv * dstore[j]),
        .rem(rem[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dd <= '0;
      vd <= '0;
      res_valid <= 1'b0;
      div_go <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            logic [PowW-1:0] ndd, nvd;
            ndd = dd;
            nvd = vd;
            if (in_rng) begin
              if (req.poly_select) begin
                dstore[req.power] <= req.coeff;
                if (req.power > vd) nvd = req.power;
              end else if (req.power > dd) begin
                ndd = req.power;
              end
            end
            dd <= ndd;
            vd <= nvd;
            if (req.last) begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (lead == '0 || vd > dd) begin
            res <= '{part: 1'b0, degree: '0, term_power: '0, result_coeff: '0,
                     error: 1'b1, end_of_run: 1'b1};
            res_valid <= 1'b1;
            dd <= '0;
            vd <= '0;
            state <= S_IDLE;
          end else begin
            qd <= dd - vd;
            idx <= dd - vd;
            div_go <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_done) begin
            qv <= div_q;
            qstore[idx] <= div_q;
            state <= S_SUB;
          end
        end
        S_SUB: begin
          if (idx == '0) begin
            idx <= dd;
            rd <= '0;
            state <= S_SCAN;
          end else begin
            idx <= idx - 1'b1;
            div_go <= 1'b1;
            state <= S_WAIT;
          end
        end
        S_SCAN: begin
          // walk down from the top, stop at the first nonzero term
          if (rem[idx] != '0 || idx == '0) begin
            rd <= (rem[idx] != '0) ? idx : '0;
            idx <= qd;
            state <= S_OUTQ;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_OUTQ: begin
          res <= '{part: 1'b0, degree: qd, term_power: idx, result_coeff: qstore[idx],
                   error: 1'b0, end_of_run: 1'b0};
          res_valid <= 1'b1;
          if (idx == '0) begin
            idx <= rd;
            state <= S_OUTR;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        S_OUTR: begin
          res <= '{part: 1'b1, degree: rd, term_power: idx, result_coeff: rem[idx],
                   error: 1'b0, end_of_run: idx == '0};
          res_valid <= 1'b1;
          if (idx == '0) begin
            dd <= '0;
            vd <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    lead = dstore[vd];
  end
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench;
  import pld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemCount = 400;
  localparam int QuietFrom = 340;
  localparam longint CycleLimit = 3000000;

  typedef struct {
    req_t rq;
    int   ntyped;
    res_t t0;
    res_t t1;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic res_valid;
  res_t res;

  polynomial_long_division dut (
    .clk(clk), .rst(rst), .start(start), .req(req),
    .busy(busy), .res_valid(res_valid), .res(res)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block's stores and degrees.
  logic [31:0] rem_mem [32];
  logic [31:0] dvs_mem [32];
  logic [31:0] quo_mem [32];
  logic [31:0] rem_ok;
  logic [31:0] dvs_ok;
  logic [4:0]  dvd_deg;
  logic [4:0]  dvs_deg;

  res_t owed_terms[$];
  int   mismatches = 0;
  int   sent = 0;
  longint cycles = 0;

  task automatic report(input string what);
    mismatches++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic logic [31:0] trunc_quot(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ma, mb, m;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    m = ma / mb;
    return (a[31] ^ b[31]) ? -m : m;
  endfunction

  function automatic res_t term(input logic part, input logic [4:0] deg,
                                input logic [4:0] pw, input logic [31:0] c,
                                input logic err, input logic eor);
    res_t t;
    t.part = part; t.degree = deg; t.term_power = pw;
    t.result_coeff = c; t.error = err; t.end_of_run = eor;
    return t;
  endfunction

  task automatic long_divide(input req_t r, output res_t out[$]);
    logic [4:0] dd, vd, qd, rd;
    logic [31:0] lead, q;
    out = {};
    if (r.poly_select) begin
      dvs_mem[r.power] = r.coeff;
      dvs_ok[r.power] = 1'b1;
      if (r.power > dvs_deg) dvs_deg = r.power;
    end else begin
      rem_mem[r.power] = r.coeff;
      rem_ok[r.power] = 1'b1;
      if (r.power > dvd_deg) dvd_deg = r.power;
    end
    if (!r.last) return;
    dd = dvd_deg;
    vd = dvs_deg;
    dvd_deg = '0;
    dvs_deg = '0;
    lead = dvs_mem[vd];
    if (lead == 0 || vd > dd) begin
      out.push_back(term(1'b0, 5'd0, 5'd0, 32'd0, 1'b1, 1'b1));
      return;
    end
    qd = dd - vd;
    for (int i = qd; i >= 0; i--) begin
      q = trunc_quot(rem_mem[i + vd], lead);
      quo_mem[i] = q;
      for (int j = vd; j >= 0; j--) rem_mem[(i + j) & 31] -= q * dvs_mem[j];
    end
    rd = '0;
    for (int i = dd; i >= 0; i--) begin
      if (rem_mem[i] != 0) begin
        rd = 5'(i);
        break;
      end
    end
    for (int i = qd; i >= 0; i--)
      out.push_back(term(1'b0, qd, 5'(i), quo_mem[i], 1'b0, 1'b0));
    for (int i = rd; i >= 0; i--)
      out.push_back(term(1'b1, rd, 5'(i), rem_mem[i], 1'b0, i == 0));
  endtask

  // Drop last if the run would read a store entry never written.
  function automatic req_t guard_last(input req_t r);
    logic [31:0] rk, dk;
    logic [4:0] dd, vd;
    rk = rem_ok; dk = dvs_ok; dd = dvd_deg; vd = dvs_deg;
    if (r.poly_select) begin
      dk[r.power] = 1'b1;
      if (r.power > vd) vd = r.power;
    end else begin
      rk[r.power] = 1'b1;
      if (r.power > dd) dd = r.power;
    end
    for (int i = 0; i <= dd; i++) if (!rk[i]) r.last = 1'b0;
    for (int i = 0; i <= vd; i++) if (!dk[i]) r.last = 1'b0;
    return r;
  endfunction

  function automatic req_t mk(input logic sel, input logic [4:0] pw,
                              input logic [31:0] c, input logic lst);
    req_t r;
    r.poly_select = sel; r.power = pw; r.coeff = c; r.last = lst;
    return r;
  endfunction

  function automatic logic [31:0] rand_coeff();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'd0;
      default: return $urandom_range(0, 18) - 9;
    endcase
  endfunction

  task automatic send(input req_t r, input int ntyped, input res_t t0, input res_t t1);
    res_t got[$];
    if (sent < QuietFrom && $urandom_range(0, 3) == 0) begin
      @(negedge clk) start <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    long_divide(r, got);
    if (ntyped > 0) begin
      owed_terms.push_back(t0);
      if (ntyped > 1) owed_terms.push_back(t1);
    end else begin
      foreach (got[k]) owed_terms.push_back(got[k]);
    end
    sent++;
  endtask

  always @(posedge clk) begin
    res_t w;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst && res_valid) begin
      if (owed_terms.size() == 0) begin
        report("result with nothing expected");
      end else begin
        w = owed_terms.pop_front();
        if (res.part !== w.part) report($sformatf("part %0d want %0d", res.part, w.part));
        if (res.degree !== w.degree)
          report($sformatf("degree %0d want %0d", res.degree, w.degree));
        if (res.term_power !== w.term_power)
          report($sformatf("term_power %0d want %0d", res.term_power, w.term_power));
        if (res.result_coeff !== w.result_coeff)
          report($sformatf("coeff %h want %h", res.result_coeff, w.result_coeff));
        if (res.error !== w.error) report($sformatf("error %0d want %0d", res.error, w.error));
        if (res.end_of_run !== w.end_of_run)
          report($sformatf("end_of_run %0d want %0d", res.end_of_run, w.end_of_run));
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    req_t seq[$];
    req_t r, tmp;
    int dd, vd, k;
    res_t none;
    none = '0;
    rem_ok = '0; dvs_ok = '0; dvd_deg = '0; dvs_deg = '0;

    rw.ntyped = 0; rw.t0 = none; rw.t1 = none;
    rw.rq = mk(0, 0, 5, 0); rows.push_back(rw);
    // zero leading divisor coefficient
    rw.rq = mk(1, 0, 0, 1); rw.ntyped = 1;
    rw.t0 = term(0, 0, 0, 0, 1, 1); rows.push_back(rw);
    // divisor degree above dividend degree
    rw.rq = mk(1, 1, 7, 1); rows.push_back(rw);
    rw.ntyped = 0;
    rw.rq = mk(0, 0, 32'h8000_0000, 0); rows.push_back(rw);
    // most negative over minus one wraps
    rw.rq = mk(1, 0, 32'hffff_ffff, 1); rw.ntyped = 2;
    rw.t0 = term(0, 0, 0, 32'h8000_0000, 0, 0);
    rw.t1 = term(1, 0, 0, 0, 0, 1); rows.push_back(rw);
    rw.ntyped = 0; rw.t0 = none; rw.t1 = none;
    rw.rq = mk(0, 1, 32'h7fff_ffff, 0); rows.push_back(rw);
    rw.rq = mk(0, 0, 3, 0); rows.push_back(rw);
    rw.rq = mk(1, 1, 2, 0); rows.push_back(rw);
    rw.rq = mk(1, 0, 1, 1); rows.push_back(rw);
    // last on a dividend request
    rw.rq = mk(1, 0, 3, 0); rows.push_back(rw);
    rw.rq = mk(0, 0, 100, 1); rows.push_back(rw);
    rw.rq = mk(0, 2, -7, 0); rows.push_back(rw);
    rw.rq = mk(0, 1, 0, 0); rows.push_back(rw);
    rw.rq = mk(0, 0, 9, 0); rows.push_back(rw);
    rw.rq = mk(1, 1, -2, 0); rows.push_back(rw);
    rw.rq = mk(1, 0, 32'h8000_0000, 1); rows.push_back(rw);

    repeat (4) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (rows[i]) send(rows[i].rq, rows[i].ntyped, rows[i].t0, rows[i].t1);

    while (sent < ItemCount) begin
      if ($urandom_range(0, 4) != 0) begin
        dd = ($urandom_range(0, 15) == 0) ? 31 : $urandom_range(0, 6);
        vd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, dd);
        seq = {};
        for (int i = 0; i <= dd; i++) seq.push_back(mk(0, i, rand_coeff(), 0));
        for (int i = 0; i < vd; i++) seq.push_back(mk(1, i, rand_coeff(), 0));
        seq.push_back(mk(1, vd, ($urandom_range(0, 7) == 0) ? 0 :
                         (($urandom_range(0, 3) == 0) ? rand_coeff() :
                          $urandom_range(1, 3) * ($urandom_range(0, 1) ? 1 : -1)), 0));
        for (int i = seq.size() - 1; i > 0; i--) begin
          k = $urandom_range(0, i);
          tmp = seq[i]; seq[i] = seq[k]; seq[k] = tmp;
        end
        seq[seq.size() - 1].last = 1'b1;
        foreach (seq[i]) send(guard_last(seq[i]), 0, none, none);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          r = mk($urandom_range(0, 1), $urandom_range(0, 31), rand_coeff(),
                 $urandom_range(0, 3) == 0);
          send(guard_last(r), 0, none, none);
        end
      end
    end

    @(negedge clk) start <= 1'b0;
    while (owed_terms.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
